/* rtl/tplru_pkg.sv */
// Package: widths, types and tree pseudo-LRU helper functions for the set replacement block.
`default_nettype none

package tplru_pkg;

   localparam int Ways     = 8;
   localparam int TagBits  = 32;
   localparam int WayBits  = $clog2(Ways);
   localparam int Levels   = $clog2(Ways + 1) - 1;
   localparam int TreeBits = Ways - 1;

   typedef logic [TagBits-1:0]              tag_type;
   typedef logic [WayBits-1:0]              way_type;
   typedef logic [Levels-1:0]               out_way_type;
   typedef logic [TreeBits-1:0]             tree_type;
   typedef logic [Ways-1:0]                 valid_type;
   typedef logic [Ways-1:0][TagBits-1:0]    row_type;

   typedef struct packed {
      way_type  way;
      tree_type tree;
   } victim_type;

   typedef struct packed {
      logic     hit;
      way_type  way;
      logic     evict_valid;
      tag_type  evict_tag;
      logic     write;
      row_type  row;
      valid_type valid;
      tree_type tree;
   } decision_type;

   function automatic tree_type touch_path(input tree_type bits_in, input way_type way);
      tree_type b;
      int       look;
      logic     right;
      logic     stop;
      b    = bits_in;
      look = 0;
      stop = 1'b0;
      for (int i = 0; i < Levels; i++) begin
         right = way[Levels-1-i];
         if (look >= TreeBits) stop = 1'b1;
         if (!stop) begin
            if (right) begin
               b[look] = 1'b0;
               look    = look + (Ways >> (i + 1));
            end else begin
               b[look] = 1'b1;
               look    = look + 1;
            end
         end
      end
      return b;
   endfunction

   function automatic victim_type walk_victim(input tree_type bits_in);
      victim_type res;
      tree_type   b;
      int         look;
      int         v;
      logic       bit_now;
      b    = bits_in;
      look = 0;
      v    = 0;
      for (int i = 0; i < Levels; i++) begin
         bit_now = 1'b0;
         if (look < TreeBits) begin
            bit_now = b[look];
            b[look] = ~b[look];
         end
         v    = (v << 1) | int'(bit_now);
         look = look + (bit_now ? (Ways >> (i + 1)) : 1);
      end
      if (v >= Ways) v = Ways - 1;
      res.way  = WayBits'(v);
      res.tree = b;
      return res;
   endfunction

endpackage

`default_nettype wire

/* rtl/tplru_if.sv */
// Interfaces: request and response channels of the set replacement block.
`default_nettype none

interface tplru_req_if;
   logic                      valid;
   logic                      ready;
   logic [tplru_pkg::TagBits-1:0] tag;

   modport source (output valid, output tag, input ready);
   modport sink   (input valid, input tag, output ready);
endinterface

interface tplru_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         hit;
   logic [tplru_pkg::Levels-1:0] way;
   logic                         evicted_valid;
   logic [tplru_pkg::TagBits-1:0] evicted_tag;

   modport source (output valid, output hit, output way, output evicted_valid,
                   output evicted_tag, input ready);
   modport sink   (input valid, input hit, input way, input evicted_valid,
                   input evicted_tag, output ready);
endinterface

`default_nettype wire

/* rtl/tree_plru_set_replacement.sv */
// Top level: one cache set with tree pseudo-LRU replacement over a tag memory.
//
//   channel   direction  word                                        handshake
//   req_chan  in         tag                                         valid/ready
//   rsp_chan  out        hit, way, evicted_valid, evicted_tag        valid/ready
//
// Each word is accepted in IDLE, then compared and updated in LOOK against the
// tag row read from the registered tag memory; no new word is accepted until LOOK
// commits. Reset empties every way and clears the tree; no clearing pass.
// A stalled response register holds the update until it can be loaded.
`default_nettype none

module tree_plru_set_replacement (
   input  wire                clock,
   input  wire                reset,
   tplru_req_if.sink          req_chan,
   tplru_rsp_if.source        rsp_chan
);

   typedef enum logic {
      IDLE,
      LOOK
   } state_type;

   state_type                state_ff;
   tplru_pkg::tag_type       tag_ff;
   tplru_pkg::valid_type     valid_ff;
   tplru_pkg::tree_type      tree_ff;
   logic                     rsp_valid_ff;
   logic                     hit_ff;
   tplru_pkg::out_way_type   way_ff;
   logic                     evict_valid_ff;
   tplru_pkg::tag_type       evict_tag_ff;

   tplru_pkg::row_type       rd_row;
   tplru_pkg::decision_type  dec;
   logic                     commit;

   tplru_tag_store u_store (
      .clock  (clock),
      .wr_en  (commit && dec.write),
      .wr_row (dec.row),
      .rd_row (rd_row)
   );

   tplru_decide u_decide (
      .tag   (tag_ff),
      .row   (rd_row),
      .valid (valid_ff),
      .tree  (tree_ff),
      .dec   (dec)
   );

   assign commit         = (state_ff == LOOK) && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = (state_ff == IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         valid_ff     <= '0;
         tree_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            IDLE: begin
               if (req_chan.valid) begin
                  tag_ff   <= req_chan.tag;
                  state_ff <= LOOK;
               end
            end
            LOOK: begin
               if (commit) begin
                  valid_ff       <= dec.valid;
                  tree_ff        <= dec.tree;
                  hit_ff         <= dec.hit;
                  way_ff         <= dec.way[tplru_pkg::Levels-1:0];
                  evict_valid_ff <= dec.evict_valid;
                  evict_tag_ff   <= dec.evict_tag;
                  state_ff       <= IDLE;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.hit           = hit_ff;
   assign rsp_chan.way           = way_ff;
   assign rsp_chan.evicted_valid = evict_valid_ff;
   assign rsp_chan.evicted_tag   = evict_tag_ff;

endmodule

`default_nettype wire

/* rtl/tplru_tag_store.sv */
// Tag store: one-row synchronous memory holding the tags of every way.
`default_nettype none

module tplru_tag_store (
   input  wire                 clock,
   input  wire                 wr_en,
   input  tplru_pkg::row_type  wr_row,
   output tplru_pkg::row_type  rd_row
);

   tplru_pkg::row_type mem [1];
   tplru_pkg::row_type rd_row_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[0] <= wr_row;
      end
      rd_row_ff <= mem[0];
   end

   assign rd_row = rd_row_ff;

endmodule

`default_nettype wire

/* rtl/tplru_decide.sv */
// Decision logic: tag compare, hit path touch or victim walk, and next set state.
`default_nettype none

module tplru_decide (
   input  tplru_pkg::tag_type      tag,
   input  tplru_pkg::row_type      row,
   input  tplru_pkg::valid_type    valid,
   input  tplru_pkg::tree_type     tree,
   output tplru_pkg::decision_type dec
);

   logic                   hit;
   tplru_pkg::way_type     hit_way;
   tplru_pkg::victim_type  victim;

   always_comb begin
      hit     = 1'b0;
      hit_way = '0;
      for (int i = tplru_pkg::Ways - 1; i >= 0; i--) begin
         if (valid[i] && (row[i] == tag)) begin
            hit     = 1'b1;
            hit_way = tplru_pkg::WayBits'(i);
         end
      end
   end

   assign victim = tplru_pkg::walk_victim(tree);

   always_comb begin
      dec.hit         = hit;
      dec.row         = row;
      dec.valid       = valid;
      dec.evict_valid = 1'b0;
      dec.evict_tag   = '0;
      if (hit) begin
         dec.way   = hit_way;
         dec.write = 1'b0;
         dec.tree  = tplru_pkg::touch_path(tree, hit_way);
      end else begin
         dec.way         = victim.way;
         dec.write       = 1'b1;
         dec.tree        = victim.tree;
         dec.evict_valid = valid[victim.way];
         dec.evict_tag   = valid[victim.way] ? row[victim.way] : '0;
         dec.row[victim.way]   = tag;
         dec.valid[victim.way] = 1'b1;
      end
   end

endmodule

`default_nettype wire

/* verif/tree_plru_set_replacement_tb.sv */
// Testbench: checks every access word of the tree pseudo-LRU set against a local predictor.
`timescale 1ns / 1ps

module tree_plru_set_replacement_tb;
   import tplru_pkg::*;

   localparam int WatchdogLimit = 2000;
   localparam int SettleCycles  = 16;

   typedef struct packed {
      logic        hit;
      out_way_type way;
      logic        evicted_valid;
      tag_type     evicted_tag;
   } access_result_t;

   logic clock;
   logic reset;

   tplru_req_if req_bus ();
   tplru_rsp_if rsp_bus ();

   tree_plru_set_replacement u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // predicted contents of the set
   valid_type held_valid;
   tag_type   held_tag [Ways];
   tree_type  plru_tree;

   access_result_t expected_results [$];
   logic           steady;
   int             mismatches;
   int             words_sent;
   int             hits_seen;
   int             evictions_seen;
   tag_type        tag_pool [$];

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_bus.ready <= steady || ($urandom_range(0, 99) >= 10);
      end
   end

   task automatic predict_access(input tag_type t, output access_result_t r);
      int   idx;
      int   v;
      logic dir;
      logic found;
      out_way_type w;
      found = 1'b0;
      w     = '0;
      r     = '0;
      for (int i = 0; i < Ways; i++) begin
         if (!found && held_valid[i] && held_tag[i] == t) begin
            found = 1'b1;
            w     = out_way_type'(i);
         end
      end
      idx = 0;
      if (found) begin
         // point every node on the path away from the hit way
         for (int lvl = 0; lvl < Levels; lvl++) begin
            dir = w[Levels-1-lvl];
            if (idx < TreeBits) plru_tree[idx] = ~dir;
            idx = idx + (dir ? (Ways >> (lvl + 1)) : 1);
         end
         r.hit = 1'b1;
         r.way = w;
      end else begin
         v = 0;
         for (int lvl = 0; lvl < Levels; lvl++) begin
            dir = 1'b0;
            if (idx < TreeBits) begin
               dir            = plru_tree[idx];
               plru_tree[idx] = ~dir;
            end
            v   = v * 2 + int'(dir);
            idx = idx + (dir ? (Ways >> (lvl + 1)) : 1);
         end
         if (v >= Ways) v = Ways - 1;
         if (held_valid[v]) begin
            r.evicted_valid = 1'b1;
            r.evicted_tag   = held_tag[v];
         end
         held_tag[v]   = t;
         held_valid[v] = 1'b1;
         r.way         = out_way_type'(v);
      end
   endtask

   task automatic send_tag(input tag_type t);
      access_result_t r;
      if (!steady && $urandom_range(0, 99) < 10) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.tag   <= t;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      predict_access(t, r);
      expected_results.push_back(r);
      words_sent++;
   endtask

   always @(posedge clock) begin
      access_result_t want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (expected_results.size() == 0) begin
            $error("unexpected response word: hit=%0b way=%0d ev=%0b tag=%h",
                   rsp_bus.hit, rsp_bus.way, rsp_bus.evicted_valid, rsp_bus.evicted_tag);
            mismatches++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_bus.hit !== want.hit) begin
               $error("hit: expected %0b, actual %0b", want.hit, rsp_bus.hit);
               mismatches++;
            end
            if (rsp_bus.way !== want.way) begin
               $error("way: expected %0d, actual %0d", want.way, rsp_bus.way);
               mismatches++;
            end
            if (rsp_bus.evicted_valid !== want.evicted_valid) begin
               $error("evicted_valid: expected %0b, actual %0b",
                      want.evicted_valid, rsp_bus.evicted_valid);
               mismatches++;
            end
            if (rsp_bus.evicted_tag !== want.evicted_tag) begin
               $error("evicted_tag: expected %h, actual %h",
                      want.evicted_tag, rsp_bus.evicted_tag);
               mismatches++;
            end
            if (want.hit) hits_seen++;
            if (want.evicted_valid) evictions_seen++;
         end
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WatchdogLimit) begin
         @(posedge clock);
         if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
             (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("watchdog: no word moved for %0d cycles", WatchdogLimit);
      $display("RESULT: ERROR");
      $finish;
   end

   task automatic wait_drained();
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   // fill the empty set, with hits mixed in so the tree is moved between fills
   task automatic test_cold_fill();
      send_tag(32'h0000_0000);
      send_tag(32'h0000_0000);
      send_tag(32'hFFFF_FFFF);
      send_tag(32'h0000_0000);
      send_tag(32'h0000_0001);
      send_tag(32'h8000_0000);
      send_tag(32'hAAAA_AAAA);
      send_tag(32'hFFFF_FFFF);
      send_tag(32'h5555_5555);
      send_tag($urandom());
      send_tag($urandom());
      send_tag(32'h7FFF_FFFE);
   endtask

   task automatic test_hit_refresh();
      send_tag(32'h5555_5555);
      send_tag(32'hAAAA_AAAA);
      send_tag(32'h0000_0001);
      send_tag(32'h8000_0000);
   endtask

   task automatic test_eviction();
      send_tag(32'h1234_5678);
      send_tag(32'hFEDC_BA98);
      send_tag(32'h0F0F_0F0F);
      send_tag(32'hF0F0_F0F0);
      send_tag(32'h0000_0000);
      send_tag(32'hFFFF_FFFF);
      send_tag(32'h1234_5678);
   endtask

   task automatic fill_pool(input int n);
      tag_pool.delete();
      for (int i = 0; i < n; i++) tag_pool.push_back($urandom());
   endtask

   // reuse a pool of tags; a few random tags stand in as noise
   task automatic run_pool(input int count, input int pool_size);
      fill_pool(pool_size);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < 15)
            send_tag($urandom());
         else
            send_tag(tag_pool[$urandom_range(0, pool_size - 1)]);
      end
   endtask

   task automatic test_thrash();
      run_pool(250, 10);
   endtask

   task automatic test_hot_set();
      steady = 1'b1;
      run_pool(150, 6);
      steady = 1'b0;
   endtask

   task automatic test_wide_pool();
      run_pool(230, 16);
   endtask

   task automatic test_random_tags();
      tag_type t;
      for (int i = 0; i < 120; i++) begin
         t = $urandom();
         send_tag(t);
         if ($urandom_range(0, 3) == 0) send_tag(t);
      end
   endtask

   initial begin
      reset         <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.tag   <= '0;
      steady         = 1'b0;
      mismatches     = 0;
      words_sent     = 0;
      hits_seen      = 0;
      evictions_seen = 0;
      held_valid     = '0;
      plru_tree      = '0;
      for (int i = 0; i < Ways; i++) held_tag[i] = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_cold_fill();
      test_hit_refresh();
      test_eviction();
      test_thrash();
      test_hot_set();
      test_wide_pool();
      test_random_tags();

      req_bus.valid <= 1'b0;
      wait_drained();
      repeat (SettleCycles) @(posedge clock);
      if (expected_results.size() != 0) begin
         $error("%0d expected response words never arrived", expected_results.size());
         mismatches++;
      end

      $display("covered %0d accesses over %0d ways: %0d hits, %0d evictions",
               words_sent, Ways, hits_seen, evictions_seen);
      $display("cold fill, hit refresh, eviction, thrashing and random tags, with stalls");
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
